/* hdl/fcts_pkg.sv */
package fcts_pkg;

   localparam int SEC_IDX_W  = 5;
   localparam int TAP_W      = 5;
   localparam int ORD_W      = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAP_STAGE_COUNT      = 1'b0,
      CSR_COEFFICIENT_ORDERING = 1'b1
   } csr_index_type;

   localparam logic [ORD_W-1:0] ORD_INTERLEAVED = 2'd0;
   localparam logic [ORD_W-1:0] ORD_DESCENDING  = 2'd1;
   localparam logic [ORD_W-1:0] ORD_ASCENDING   = 2'd2;

   localparam logic [TAP_W-1:0] TAP_RESET = 5'd16;
   localparam logic [ORD_W-1:0] ORD_RESET = ORD_INTERLEAVED;

   typedef logic signed [15:0] coef_type;
   typedef logic [3:0]         rank_type;
   typedef logic [15:0]        scale_type;

   // Q2.14 c0 of each coefficient rank; rank zero has no s1 term.
   localparam coef_type RANK_C0 [16] = '{
      16'sd16384,  16'sd32138,  16'sd30274,  16'sd27246,
      16'sd23170,  16'sd18205,  16'sd12540,  16'sd6393,
      16'sd0,     -16'sd6393,  -16'sd12540, -16'sd18205,
     -16'sd23170, -16'sd27246, -16'sd30274, -16'sd32138
   };

   localparam rank_type PLACE_INTERLEAVED [16] = '{
      4'd8, 4'd1, 4'd15, 4'd2, 4'd14, 4'd3, 4'd13, 4'd4,
      4'd12, 4'd5, 4'd11, 4'd6, 4'd10, 4'd7, 4'd9, 4'd0
   };

   // Q0.16 output gain of roughly one over twice the tap count, by tap count.
   localparam scale_type SCALE [33] = '{
      16'd0,    16'd32768, 16'd16384, 16'd10923, 16'd8192, 16'd6554, 16'd5461,
      16'd4681, 16'd4096,  16'd3641,  16'd3277,  16'd2979, 16'd2731, 16'd2521,
      16'd2341, 16'd2185,  16'd2048,  16'd1928,  16'd1820, 16'd1725, 16'd1638,
      16'd1560, 16'd1489,  16'd1425,  16'd1365,  16'd1311, 16'd1260, 16'd1214,
      16'd1170, 16'd1130,  16'd1092,  16'd1057,  16'd1024
   };

   function automatic rank_type rank_of(logic [ORD_W-1:0] ord, logic [3:0] pos);
      rank_type r;
      case (ord)
         ORD_DESCENDING: r = ~pos;
         ORD_ASCENDING:  r = pos;
         default:        r = PLACE_INTERLEAVED[pos];
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic                 load_in;
      logic                 run;
      logic                 mul;
      logic                 load_out;
      logic [SEC_IDX_W-1:0] sec;
      logic [SEC_IDX_W-1:0] rd_addr;
   } cmd_type;

   typedef struct packed {
      logic taps_zero;
      logic last;
   } status_type;

endpackage

/* hdl/fcts_chan_if.sv */
interface fcts_req_if #(parameter int SAMPLE_BITS = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface fcts_rsp_if #(parameter int SAMPLE_BITS = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

/* hdl/fcts_datapath.sv */
module fcts_datapath #(
   parameter int NUM_SECTIONS  = 16,
   parameter int SAMPLE_BITS   = 16,
   parameter int INTERNAL_BITS = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fcts_pkg::cmd_type                 cmd,
   output fcts_pkg::status_type              status,
   input  logic signed [SAMPLE_BITS-1:0]     sample_in,
   output logic signed [SAMPLE_BITS-1:0]     sample_out,
   output logic                              clipped,
   input  logic                              csr_we,
   input  logic [fcts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fcts_pkg::CSR_DATA_W-1:0]   csr_data
);
   import fcts_pkg::*;

   localparam int SB     = SAMPLE_BITS;
   localparam int IB     = INTERNAL_BITS;
   localparam int SEC_AW = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
   localparam int ACC_W  = IB + 17;
   localparam int PRD_W  = IB + 17;

   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(8192);
   localparam logic signed [PRD_W-1:0] OUT_HALF = PRD_W'(32768);
   localparam logic signed [ACC_W-1:0] INT_MAX =
      $signed({{(ACC_W-IB+1){1'b0}}, {(IB-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] INT_MIN =
      $signed({{(ACC_W-IB+1){1'b1}}, {(IB-1){1'b0}}});
   localparam logic signed [PRD_W-1:0] OUT_MAX =
      $signed({{(PRD_W-SB+1){1'b0}}, {(SB-1){1'b1}}});
   localparam logic signed [PRD_W-1:0] OUT_MIN =
      $signed({{(PRD_W-SB+1){1'b1}}, {(SB-1){1'b0}}});

   logic [TAP_W-1:0] tap_ff;
   logic [ORD_W-1:0] ord_ff;
   logic [NUM_SECTIONS-1:0] valid_ff;

   logic signed [IB-1:0] s0_mem [NUM_SECTIONS];
   logic signed [IB-1:0] s1_mem [NUM_SECTIONS];
   logic signed [IB-1:0] rd_s0_ff, rd_s1_ff;
   logic                 rd_ok_ff;

   logic signed [SB-1:0]    x_ff;
   logic signed [IB-1:0]    v_ff;
   logic                    hit_ff;
   logic                    bypass_ff;
   logic signed [PRD_W-1:0] prod_ff;
   logic signed [SB-1:0]    sample_out_ff;
   logic                    clipped_ff;

   logic [5:0]           tap_ext, taps_eff;
   logic [SEC_AW-1:0]    rd_idx, wr_idx;
   logic signed [IB-1:0] s0_eff, s1_eff;
   rank_type             rank;
   coef_type             c0;
   logic signed [IB+15:0]  p0;
   logic signed [ACC_W-1:0] s1_term, acc, rnd, y_sum;
   logic signed [IB-1:0]    y_clamp;
   logic                    sec_hit;
   logic signed [16:0]      scale_s;
   logic signed [PRD_W-1:0] r_full;
   logic signed [SB-1:0]    r_clamp;
   logic                    out_hit;

   assign tap_ext  = {1'b0, tap_ff};
   assign taps_eff = (tap_ext > 6'(NUM_SECTIONS)) ? 6'(NUM_SECTIONS) : tap_ext;

   assign status.taps_zero = (taps_eff == 6'd0);
   assign status.last      = ({1'b0, cmd.sec} == (taps_eff - 6'd1));

   assign rd_idx = cmd.rd_addr[SEC_AW-1:0];
   assign wr_idx = cmd.sec[SEC_AW-1:0];

   assign s0_eff = rd_ok_ff ? rd_s0_ff : '0;
   assign s1_eff = rd_ok_ff ? rd_s1_ff : '0;

   always_comb begin
      rank    = rank_of(ord_ff, cmd.sec[3:0]);
      c0      = RANK_C0[rank];
      p0      = c0 * s0_eff;
      s1_term = (rank != 4'd0) ? (ACC_W'(s1_eff) <<< 14) : '0;
      acc     = ACC_W'(p0) + s1_term;
      rnd     = (acc + RND_HALF) >>> 14;
      y_sum   = rnd + ACC_W'(v_ff);
      sec_hit = 1'b0;
      if (y_sum > INT_MAX) begin
         y_clamp = INT_MAX[IB-1:0];
         sec_hit = 1'b1;
      end else if (y_sum < INT_MIN) begin
         y_clamp = INT_MIN[IB-1:0];
         sec_hit = 1'b1;
      end else begin
         y_clamp = y_sum[IB-1:0];
      end
   end

   assign scale_s = $signed({1'b0, SCALE[taps_eff]});

   always_comb begin
      r_full  = (prod_ff + OUT_HALF) >>> 16;
      out_hit = 1'b0;
      if (r_full > OUT_MAX) begin
         r_clamp = OUT_MAX[SB-1:0];
         out_hit = 1'b1;
      end else if (r_full < OUT_MIN) begin
         r_clamp = OUT_MIN[SB-1:0];
         out_hit = 1'b1;
      end else begin
         r_clamp = r_full[SB-1:0];
      end
   end

   // A write of a defined ordering value drops every stored delay at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff   <= TAP_RESET;
         ord_ff   <= ORD_RESET;
         valid_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TAP_STAGE_COUNT: begin
               tap_ff <= csr_data[TAP_W-1:0];
            end
            CSR_COEFFICIENT_ORDERING: begin
               if (csr_data[ORD_W-1:0] <= ORD_ASCENDING) begin
                  ord_ff   <= csr_data[ORD_W-1:0];
                  valid_ff <= '0;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.run) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_s0_ff <= s0_mem[rd_idx];
      rd_s1_ff <= s1_mem[rd_idx];
      rd_ok_ff <= valid_ff[rd_idx];
      if (cmd.run) begin
         s0_mem[wr_idx] <= v_ff;
         s1_mem[wr_idx] <= s0_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         x_ff      <= sample_in;
         v_ff      <= IB'(sample_in);
         hit_ff    <= 1'b0;
         bypass_ff <= status.taps_zero;
      end else if (cmd.run) begin
         v_ff   <= y_clamp;
         hit_ff <= hit_ff | sec_hit;
      end
      if (cmd.mul) begin
         prod_ff <= v_ff * scale_s;
      end
      if (cmd.load_out) begin
         sample_out_ff <= bypass_ff ? x_ff : r_clamp;
         clipped_ff    <= bypass_ff ? 1'b0 : (hit_ff | out_hit);
      end
   end

   assign sample_out = sample_out_ff;
   assign clipped    = clipped_ff;

endmodule

/* hdl/fcts_controller.sv */
module fcts_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fcts_pkg::cmd_type    cmd,
   input  fcts_pkg::status_type status
);
   import fcts_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_MUL,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [SEC_IDX_W-1:0] sec_ff, sec_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      sec_in       = sec_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.sec      = sec_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.rd_addr = '0;
            if (accept) begin
               cmd.load_in = 1'b1;
               sec_in      = '0;
               state_in    = status.taps_zero ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.run     = 1'b1;
            cmd.rd_addr = sec_ff + 1'b1;
            sec_in      = sec_ff + 1'b1;
            if (status.last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sec_ff       <= sec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/fir_cascade_tap_select.sv */
// Channel   Direction  Contents
// req_if    in         sample_in, signed Q1.15
// rsp_if    out        sample_out, signed Q1.15 saturated; clipped
// csr_*     in         csr_we, csr_index, csr_data (tap count, ordering)
//
// After acceptance a request with a tap count of k passes its k sections in turn
// through the shared multiply-accumulate, then the output gain multiply, and is
// then rounded and saturated into the result register once that register is free
// to take it. A tap count of zero skips straight to the result register, taking
// the input sample unchanged. The controller then returns to idle for the next request.
// Reset is synchronous and clears the delay line at once through per-section valid
// bits, as does a write of a defined ordering value.
// One request is in flight at a time; a finished result waits in the output
// register while the next request is accepted and processed.
module fir_cascade_tap_select #(
   parameter int NUM_SECTIONS  = 16,
   parameter int SAMPLE_BITS   = 16,
   parameter int INTERNAL_BITS = 48
) (
   input  logic                            clock,
   input  logic                            reset,
   fcts_req_if.sink                        req_if,
   fcts_rsp_if.source                      rsp_if,
   input  logic                            csr_we,
   input  logic [fcts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fcts_pkg::CSR_DATA_W-1:0] csr_data
);
   import fcts_pkg::*;

   cmd_type    cmd;
   status_type status;

   fcts_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   fcts_datapath #(
      .NUM_SECTIONS  (NUM_SECTIONS),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .INTERNAL_BITS (INTERNAL_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .sample_in  (req_if.sample_in),
      .sample_out (rsp_if.sample_out),
      .clipped    (rsp_if.clipped),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

endmodule

/* tb/fir_cascade_tap_select_tb.sv */
module fir_cascade_tap_select_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fcts_pkg::*;

   localparam int          NUM_SECTIONS  = 16;
   localparam int          SAMPLE_BITS   = 16;
   localparam int          INTERNAL_BITS = 48;
   localparam int          CYCLE_LIMIT   = 500000;
   localparam int          HOLD_CYCLES   = 400;
   localparam logic [1:0]  ORD_UNDEFINED = 2'd3;

   typedef struct {
      logic signed [15:0] sample_out;
      logic               clipped;
   } filter_output_type;

   class fir_scoreboard;
      logic [TAP_W-1:0]   tap_reg;
      logic [ORD_W-1:0]   ord_reg;
      longint             delays [NUM_SECTIONS][2];
      filter_output_type  expected_outputs [$];
      int                 errors;
      int                 requests;
      int                 bypassed;
      int                 clipped_count;
      int                 csr_writes;

      function new();
         tap_reg = 5'd16;
         ord_reg = ORD_INTERLEAVED;
         clear_delays();
         errors = 0;
         requests = 0;
         bypassed = 0;
         clipped_count = 0;
         csr_writes = 0;
      endfunction

      function void clear_delays();
         foreach (delays[i, j]) delays[i][j] = 0;
      endfunction

      function longint saturate(longint val, int bits, inout bit hit);
         longint hi;
         longint lo;
         hi = (longint'(1) << (bits - 1)) - 1;
         lo = -hi - 1;
         if (val > hi) begin
            hit = 1'b1;
            return hi;
         end
         if (val < lo) begin
            hit = 1'b1;
            return lo;
         end
         return val;
      endfunction

      function int section_rank(int pos);
         int interleaved [16] = '{8, 1, 15, 2, 14, 3, 13, 4, 12, 5, 11, 6, 10, 7, 9, 0};
         case (ord_reg)
            ORD_DESCENDING: begin
               return 15 - pos;
            end
            ORD_ASCENDING: begin
               return pos;
            end
            default: begin
               return interleaved[pos];
            end
         endcase
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         logic [ORD_W-1:0] ord;
         csr_writes++;
         ord = data[ORD_W-1:0];
         if (idx == CSR_TAP_STAGE_COUNT) begin
            tap_reg = data[TAP_W-1:0];
         end else if (ord != ORD_UNDEFINED) begin
            ord_reg = ord;
            clear_delays();
         end
      endfunction

      function void note_request(logic signed [15:0] sample);
         longint            rank_c0 [16] = '{16384, 32138, 30274, 27246, 23170, 18205, 12540,
                                             6393, 0, -6393, -12540, -18205, -23170, -27246,
                                             -30274, -32138};
         filter_output_type result;
         longint            taps;
         longint            v;
         longint            y;
         longint            acc;
         longint            c1;
         longint            scale;
         longint            r;
         int                rank;
         bit                hit;
         requests++;
         hit = 1'b0;
         taps = (tap_reg > NUM_SECTIONS) ? NUM_SECTIONS : tap_reg;
         if (taps == 0) begin
            result.sample_out = sample;
            result.clipped = 1'b0;
            bypassed++;
         end else begin
            v = sample;
            for (int i = 0; i < taps; i++) begin
               rank = section_rank(i);
               c1 = (rank == 0) ? 0 : 16384;
               acc = rank_c0[rank] * delays[i][0] + c1 * delays[i][1];
               y = ((acc + 8192) >>> 14) + v;
               y = saturate(y, INTERNAL_BITS, hit);
               delays[i][1] = delays[i][0];
               delays[i][0] = v;
               v = y;
            end
            scale = (65536 + taps) / (2 * taps);
            r = (v * scale + 32768) >>> 16;
            r = saturate(r, SAMPLE_BITS, hit);
            result.sample_out = r[15:0];
            result.clipped = hit;
         end
         if (result.clipped) clipped_count++;
         expected_outputs.push_back(result);
      endfunction

      function void check_response(logic signed [15:0] sample_out, logic clipped);
         filter_output_type want;
         if (expected_outputs.size() == 0) begin
            $error("result with no request outstanding: sample_out %0d clipped %0b",
                   sample_out, clipped);
            errors++;
            return;
         end
         want = expected_outputs.pop_front();
         if (sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, actual %0d", want.sample_out, sample_out);
            errors++;
         end
         if (clipped !== want.clipped) begin
            $error("clipped: expected %0b, actual %0b", want.clipped, clipped);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   fcts_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   fcts_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();

   fir_cascade_tap_select #(
      .NUM_SECTIONS  (NUM_SECTIONS),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .INTERNAL_BITS (INTERNAL_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   fir_scoreboard sb;
   int            gap_pct = 0;
   int            stall_pct = 0;
   int            hold_requests = 0;
   int            holds_seen = 0;
   int            hold_left = 0;
   int            cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("fir_cascade_tap_select regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (csr_we) sb.write_register(csr_index, csr_data);
         if (rsp_bus.valid && rsp_bus.ready) sb.check_response(rsp_bus.sample_out, rsp_bus.clipped);
         if (req_bus.valid && req_bus.ready) sb.note_request(req_bus.sample_in);
      end
   end

   // The receiver owns its hold-off counter; the stimulus only asks for a hold.
   always @(negedge clock) begin
      if (hold_requests != holds_seen) begin
         holds_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         rsp_bus.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_sample(input logic signed [15:0] value);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.sample_in = value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] random_sample();
      logic signed [15:0] s;
      case ($urandom_range(0, 9))
         0: begin
            s = 16'sh7FFF;
         end
         1: begin
            s = 16'sh8000;
         end
         2, 3: begin
            s = $signed(16'($urandom_range(0, 511))) - 16'sd256;
         end
         default: begin
            s = 16'($urandom);
         end
      endcase
      return s;
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_sample(random_sample());
      req_bus.valid = 1'b0;
   endtask

   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (sb.expected_outputs.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_ordering(input logic [ORD_W-1:0] ord);
      write_register(CSR_COEFFICIENT_ORDERING, {3'($urandom), ord});
   endtask

   initial begin
      logic [4:0] tap_settings [8];
      logic [4:0] tap;
      tap_settings = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd2, 5'd5};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_TAP_STAGE_COUNT;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.sample_in = '0;
      rsp_bus.ready = 1'b0;
      sb = new();
      repeat (2) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Reset configuration: full chain, interleaved placement.
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'sh0001);
      send_sample(16'shFFFF);
      send_sample(16'sh4000);
      wait_drained();

      // Bypass leaves the delays alone.
      write_register(CSR_TAP_STAGE_COUNT, 5'd0);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh5555);
      send_sample(16'shAAAA);
      wait_drained();

      // A tap above the chain length acts as the full chain.
      write_register(CSR_TAP_STAGE_COUNT, 5'd20);
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      wait_drained();

      // An undefined ordering is ignored and keeps the delays.
      write_register(CSR_COEFFICIENT_ORDERING, {3'b000, ORD_UNDEFINED});
      write_register(CSR_TAP_STAGE_COUNT, 5'd1);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      wait_drained();

      write_ordering(ORD_DESCENDING);
      write_register(CSR_TAP_STAGE_COUNT, 5'd16);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      wait_drained();

      write_ordering(ORD_ASCENDING);
      write_register(CSR_TAP_STAGE_COUNT, 5'd8);
      send_sample(16'sh8000);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      wait_drained();

      write_register(CSR_TAP_STAGE_COUNT, 5'd31);
      send_sample(16'sh7FFF);
      send_sample(16'sh0000);
      wait_drained();

      for (int seg = 0; seg < 8; seg++) begin
         case (seg % 4)
            0: begin
               gap_pct = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct = 54;
               stall_pct = 0;
            end
            2: begin
               gap_pct = 0;
               stall_pct = 54;
            end
            default: begin
               gap_pct = 38;
               stall_pct = 38;
            end
         endcase
         write_register(CSR_TAP_STAGE_COUNT, tap_settings[seg]);
         write_ordering((seg == 5) ? ORD_UNDEFINED : 2'(seg % 3));
         if (seg % 4 == 0) hold_requests++;
         send_random(120);
         wait_drained();

         tap = ($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(0, 31));
         write_register(CSR_TAP_STAGE_COUNT, tap);
         if ($urandom_range(0, 1) == 1) write_ordering(2'($urandom_range(0, 3)));
         send_random(120);
         wait_drained();
      end

      repeat (30) @(negedge clock);
      if (sb.expected_outputs.size() != 0) begin
         $error("%0d expected results never arrived", sb.expected_outputs.size());
         sb.errors++;
      end
      $display("Ran %0d requests across %0d register writes: %0d bypassed, %0d clipped.",
               sb.requests, sb.csr_writes, sb.bypassed, sb.clipped_count);
      $display("Idle modes: none, sender gaps, receiver stalls, both, plus long receiver holds.");
      if (sb.errors == 0) begin
         $display("fir_cascade_tap_select regression: pass");
      end else begin
         $display("fir_cascade_tap_select regression: fail");
      end
      $finish;
   end

endmodule
